// ===== hw/rtl/crc8_frame_receiver_defines.svh =====
// Assertion helpers for the frame receiver
`ifndef CRC8_FRAME_RECEIVER_DEFINES_SVH
`define CRC8_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define CRCFR_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("crcfr assertion failed");

// Next-cycle implication, held off during reset
`define CRCFR_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("crcfr assertion failed");

`endif

// ===== hw/rtl/crcfr_pkg.sv =====
package crcfr_pkg;

  // preamble bytes
  localparam logic [7:0] PRE0 = 8'h24; // '$'
  localparam logic [7:0] PRE1 = 8'h41; // 'A'

  // CRC-8 DVB-S2
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // result event codes
  localparam logic [2:0] EV_ABSORBED = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_GOOD     = 3'd2;
  localparam logic [2:0] EV_CRC_BAD  = 3'd3;
  localparam logic [2:0] EV_TOO_LONG = 3'd4;
  localparam logic [2:0] EV_PRE_BAD  = 3'd5;
  localparam logic [2:0] EV_EXTRA    = 3'd6;
  localparam logic [2:0] EV_RELEASED = 3'd7;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [7:0] frame_length;
  } out_item_t;

endpackage

// ===== hw/rtl/crcfr_crc8_byte.sv =====
// One-byte CRC-8 update, MSB first
module crcfr_crc8_byte (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] v;
    v = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ crcfr_pkg::CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    crc_out = v;
  end

endmodule

// ===== hw/rtl/crcfr_parser.sv =====
// Frame state and per-item decode; state advances when fire is high
module crcfr_parser #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  crcfr_pkg::in_item_t  item,
  output crcfr_pkg::out_item_t result
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] expected_length, expected_length_next;
  logic [7:0] received_count, received_count_next;
  logic [7:0] crc_upd;
  logic [7:0] count_inc;

  crcfr_crc8_byte u_crc (
    .crc_in  (running_crc),
    .data    (item.rx_byte),
    .crc_out (crc_upd)
  );

  assign count_inc = received_count + 8'd1;

  always_comb begin
    phase_next           = phase;
    running_crc_next     = running_crc;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    result               = '0;
    result.event_res     = crcfr_pkg::EV_ABSORBED;

    if (item.operation) begin
      if (phase == PH_DONE) begin
        phase_next           = PH_HUNT;
        running_crc_next     = '0;
        expected_length_next = '0;
        received_count_next  = '0;
        result.event_res     = crcfr_pkg::EV_RELEASED;
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          if (item.rx_byte == crcfr_pkg::PRE0) begin
            phase_next = PH_SYNC;
          end
        end
        PH_SYNC: begin
          if (item.rx_byte == crcfr_pkg::PRE1) begin
            phase_next = PH_LEN;
          end else begin
            phase_next           = PH_HUNT;
            running_crc_next     = '0;
            expected_length_next = '0;
            received_count_next  = '0;
            result.event_res     = crcfr_pkg::EV_PRE_BAD;
          end
        end
        PH_LEN: begin
          if (item.rx_byte > MaxLen) begin
            phase_next           = PH_HUNT;
            running_crc_next     = '0;
            expected_length_next = '0;
            received_count_next  = '0;
            result.event_res     = crcfr_pkg::EV_TOO_LONG;
          end else begin
            running_crc_next     = crc_upd;
            expected_length_next = item.rx_byte;
            phase_next           = (item.rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
          end
        end
        PH_DATA: begin
          result.event_res    = crcfr_pkg::EV_PAYLOAD;
          result.payload_byte = item.rx_byte;
          result.byte_index   = received_count[6:0];
          running_crc_next    = crc_upd;
          received_count_next = count_inc;
          if (count_inc == expected_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          result.frame_length = expected_length;
          if (item.rx_byte != running_crc) begin
            phase_next           = PH_HUNT;
            running_crc_next     = '0;
            expected_length_next = '0;
            received_count_next  = '0;
            result.event_res     = crcfr_pkg::EV_CRC_BAD;
          end else begin
            phase_next       = PH_DONE;
            result.event_res = crcfr_pkg::EV_GOOD;
          end
        end
        PH_DONE: begin
          result.event_res = crcfr_pkg::EV_EXTRA;
        end
        default: begin
          phase_next           = PH_HUNT;
          running_crc_next     = '0;
          expected_length_next = '0;
          received_count_next  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      running_crc     <= '0;
      expected_length <= '0;
      received_count  <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      running_crc     <= running_crc_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
    end
  end

endmodule

// ===== hw/rtl/crcfr_out_stage.sv =====
// Result register with valid/ready towards the consumer
module crcfr_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  crcfr_pkg::out_item_t load_data,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crcfr_pkg::out_item_t out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== hw/rtl/crc8_frame_receiver.sv =====
// Byte-wise receiver for '$' 'A' <len> <payload...> <crc> frames, CRC-8 DVB-S2
// (poly 0xD5, init 0) over the length byte and payload.
// Input channel in_valid/in_ready/in_data: one item per handshake, either a
// received serial byte (operation 0) or a release of a completed frame (1).
// Output channel out_valid/out_ready/out_data: exactly one result item per
// input item, in order. Payload bytes come out with their index as they
// arrive; the check byte gives frame good or crc bad with the length.
// An accepted item loads the input register; it then moves into the result
// register, raising out_valid. Throughput: one item per cycle while the consumer
// keeps out_ready high, set by the combinational decode and CRC byte update.
// Stall: while the consumer holds out_ready low the result register holds;
// the input register still takes one item, then in_ready drops until the
// result is taken.
// Reset (rst, synchronous): both stages empty, receiver hunting for '$'.
// After a good frame further bytes give 'extra byte' until a release item.
module crc8_frame_receiver #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  crcfr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crcfr_pkg::out_item_t out_data
);

  `include "crc8_frame_receiver_defines.svh"

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  // input register
  logic                 s1_valid;
  crcfr_pkg::in_item_t  s1_data;
  logic                 out_can_load;
  logic                 s1_fire;
  crcfr_pkg::out_item_t result;

  // item moves from input register into result register
  assign s1_fire  = s1_valid && out_can_load;
  assign in_ready = !s1_valid || out_can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  crcfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .item   (s1_data),
    .result (result)
  );

  crcfr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid),
    .load_data  (result),
    .can_load   (out_can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // payload fields are zero unless the item carries a payload byte
  `CRCFR_ASSERT_IMP(a_payload_zero, clk, rst,
    out_valid && (out_data.event_res != crcfr_pkg::EV_PAYLOAD),
    (out_data.payload_byte == 8'd0) && (out_data.byte_index == 7'd0))

  // length only reported on frame end, and never above the limit
  `CRCFR_ASSERT_IMP(a_len_range, clk, rst,
    out_valid,
    (out_data.frame_length <= MaxLen) &&
    ((out_data.frame_length == 8'd0) ||
     (out_data.event_res == crcfr_pkg::EV_GOOD) ||
     (out_data.event_res == crcfr_pkg::EV_CRC_BAD)))

  // a full input register blocked by a stalled result holds off new items
  `CRCFR_ASSERT_NEXT(a_stall_hold, clk, rst,
    s1_valid && out_valid && !out_ready,
    s1_valid && out_valid)

endmodule
